### rtl/a2ab_pkg.sv
// ----------------------------------------------------------------------------
// a2ab_pkg: shared types and constants for the AVCC to Annex B converter
// Holds the parse phase codes, the emit descriptor handed from the parser to
// the output sequencer, and the start code table.
// ----------------------------------------------------------------------------
`default_nettype none

package a2ab_pkg;

   localparam int DEFAULT_PAD_BYTES = 32;

   // Header bytes before the SPS count: four skipped plus the length-size byte
   localparam logic [2:0] HEADER_LAST_INDEX = 3'd4;

   typedef enum logic [3:0] {
      PH_START,
      PH_S_PREFIX,
      PH_S_DATA,
      PH_R_HEADER,
      PH_R_SPSCNT,
      PH_R_PPSCNT,
      PH_R_SIZEHI,
      PH_R_SIZELO,
      PH_R_DATA,
      PH_R_DONE
   } phase_type;

   // Results caused by one request, in this order: start code, data byte, pad
   typedef struct packed {
      logic       start_code;
      logic       byte_vld;
      logic [7:0] byte_val;
      logic       byte_err;
      logic       pad;
      logic       final_mark;
   } emit_desc_type;

   function automatic logic [7:0] start_code_byte(input logic [1:0] pos);
      start_code_byte = (pos == 2'd3) ? 8'h01 : 8'h00;
   endfunction

endpackage

`default_nettype wire

### rtl/a2ab_emit.sv
// ----------------------------------------------------------------------------
// a2ab_emit: result sequencer
// Holds one emit descriptor and walks its start code, data byte and padding
// out on the response channel, one byte per accepted transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module a2ab_emit
   import a2ab_pkg::*;
#(
   parameter int PAD_BYTES = DEFAULT_PAD_BYTES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load_valid,
   input  wire emit_desc_type load_desc,
   output logic               load_ready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_byte[7:0]
   output logic               rsp_tlast,   // out_last
   output logic [0:0]         rsp_tuser    // status
);

   localparam int CNT_W = $clog2(PAD_BYTES + 6);

   logic          busy_ff, busy_in;
   emit_desc_type desc_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] total;
   logic          take;
   logic          end_item;
   logic          load;

   assign total = (desc_ff.start_code ? CNT_W'(4) : '0)
                + (desc_ff.byte_vld ? CNT_W'(1) : '0)
                + (desc_ff.pad ? CNT_W'(PAD_BYTES) : '0);

   assign end_item   = (idx_ff == total - CNT_W'(1));
   assign rsp_tvalid = busy_ff;
   assign take       = busy_ff & rsp_tready;
   assign load_ready = !busy_ff || (take && end_item);
   assign load       = load_valid & load_ready;

   always_comb begin
      rsp_tdata    = 8'h00;
      rsp_tuser[0] = 1'b0;
      if (desc_ff.start_code && (idx_ff < CNT_W'(4))) begin
         rsp_tdata = start_code_byte(idx_ff[1:0]);
      end else if (desc_ff.byte_vld && (idx_ff == '0)) begin
         rsp_tdata    = desc_ff.byte_val;
         rsp_tuser[0] = desc_ff.byte_err;
      end
      rsp_tlast = desc_ff.final_mark & end_item;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         if (end_item) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= load_desc;
      end
   end

endmodule

`default_nettype wire

### rtl/avcc_to_annexb_converter.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter: H.264 AVCC buffer to Annex B byte stream
// Parses slice buffers and configuration records byte by byte and rewrites
// length prefixes and unit sizes as start codes, padding complete records.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tlast    | tuser
//  ---------+-----+----------------+----------+--------
//  req_     | in  | in_byte[7:0]   | in_last  | mode
//  rsp_     | out | out_byte[7:0]  | out_last | status
//
// A request producing one result (slice bytes, record payload) is loaded into
// the sequencer, so such bytes flow at one per cycle while responses are taken.
// A unit size low byte yields a four-byte start code and a complete record's
// final byte adds PAD_BYTES pad bytes, sent one at a time by the single-byte
// response port of the result sequencer. Requests with no result also wait for
// the sequencer. Reset returns the parser to the start of a buffer and empties
// the sequencer. A stalled response holds the request side once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_converter
   import a2ab_pkg::*;
#(
   parameter int PAD_BYTES = DEFAULT_PAD_BYTES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte[7:0]
   input  wire logic       req_tlast,   // in_last
   input  wire logic [0:0] req_tuser,   // mode
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte[7:0]
   output logic            rsp_tlast,   // out_last
   output logic [0:0]      rsp_tuser    // status
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  header_index_ff, header_index_in;
   logic [7:0]  units_left_ff, units_left_in;
   logic        in_pps_ff, in_pps_in;
   logic [7:0]  size_hi_ff, size_hi_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [1:0]  prefix_pos_ff, prefix_pos_in;

   emit_desc_type desc;
   logic          gen;
   logic          accept;
   logic          overrun;
   logic          unit_done;
   logic          slice;
   logic [1:0]    pos;

   assign accept = req_tvalid & req_tready;

   always_comb begin
      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      units_left_in   = units_left_ff;
      in_pps_in       = in_pps_ff;
      size_hi_in      = size_hi_ff;
      payload_left_in = payload_left_ff;
      prefix_pos_in   = prefix_pos_ff;
      desc            = '0;
      overrun         = 1'b0;
      unit_done       = 1'b0;
      pos             = prefix_pos_ff;

      // sample the buffer type on its first byte
      if (phase_in == PH_START) begin
         phase_in        = req_tuser[0] ? PH_R_HEADER : PH_S_PREFIX;
         header_index_in = '0;
         prefix_pos_in   = '0;
         payload_left_in = '0;
      end
      slice = (phase_in == PH_S_PREFIX) || (phase_in == PH_S_DATA);

      unique case (phase_in)
         PH_S_PREFIX: begin
            pos             = prefix_pos_in;
            payload_left_in = (pos == 2'd0) ? {24'h0, req_tdata}
                                            : {payload_left_in[23:0], req_tdata};
            prefix_pos_in   = pos + 2'd1;
            if (prefix_pos_in == 2'd0 && payload_left_in != '0) begin
               phase_in = PH_S_DATA;
            end
            overrun       = (prefix_pos_in != 2'd0) || (phase_in == PH_S_DATA);
            desc.byte_vld = 1'b1;
            desc.byte_val = start_code_byte(pos);
         end
         PH_S_DATA: begin
            payload_left_in = payload_left_in - 32'd1;
            if (payload_left_in == '0) begin
               phase_in = PH_S_PREFIX;
            end
            overrun       = (phase_in == PH_S_DATA);
            desc.byte_vld = 1'b1;
            desc.byte_val = req_tdata;
         end
         PH_R_HEADER: begin
            if (header_index_in >= HEADER_LAST_INDEX) begin
               phase_in = PH_R_SPSCNT;
            end else begin
               header_index_in = header_index_in + 3'd1;
            end
         end
         PH_R_SPSCNT: begin
            units_left_in = {3'b000, req_tdata[4:0]};
            in_pps_in     = 1'b0;
            phase_in      = (units_left_in != '0) ? PH_R_SIZEHI : PH_R_PPSCNT;
         end
         PH_R_PPSCNT: begin
            units_left_in = req_tdata;
            in_pps_in     = 1'b1;
            phase_in      = (units_left_in != '0) ? PH_R_SIZEHI : PH_R_DONE;
         end
         PH_R_SIZEHI: begin
            size_hi_in = req_tdata;
            phase_in   = PH_R_SIZELO;
         end
         PH_R_SIZELO: begin
            payload_left_in = {16'h0, size_hi_in, req_tdata};
            desc.start_code = 1'b1;
            if (payload_left_in == '0) begin
               unit_done = 1'b1;
            end else begin
               phase_in = PH_R_DATA;
            end
         end
         PH_R_DATA: begin
            desc.byte_vld   = 1'b1;
            desc.byte_val   = req_tdata;
            payload_left_in = payload_left_in - 32'd1;
            unit_done       = (payload_left_in == '0);
         end
         default: begin
            phase_in = PH_R_DONE;
         end
      endcase

      if (unit_done) begin
         units_left_in = units_left_in - 8'd1;
         if (units_left_in != '0) begin
            phase_in = PH_R_SIZEHI;
         end else begin
            phase_in = in_pps_in ? PH_R_DONE : PH_R_PPSCNT;
         end
      end

      if (req_tlast) begin
         if (slice) begin
            desc.byte_err   = overrun;
            desc.final_mark = 1'b1;
         end else if (phase_in == PH_R_DONE) begin
            desc.pad        = 1'b1;
            desc.final_mark = 1'b1;
         end else begin
            // truncated record: drop this request's bytes, send one error result
            desc            = '0;
            desc.byte_vld   = 1'b1;
            desc.byte_err   = 1'b1;
            desc.final_mark = 1'b1;
         end
         phase_in        = PH_START;
         header_index_in = '0;
         units_left_in   = '0;
         in_pps_in       = 1'b0;
         size_hi_in      = '0;
         payload_left_in = '0;
         prefix_pos_in   = '0;
      end

      gen = desc.start_code | desc.byte_vld | (desc.pad && (PAD_BYTES != 0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         header_index_ff <= '0;
         units_left_ff   <= '0;
         in_pps_ff       <= 1'b0;
         size_hi_ff      <= '0;
         payload_left_ff <= '0;
         prefix_pos_ff   <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         units_left_ff   <= units_left_in;
         in_pps_ff       <= in_pps_in;
         size_hi_ff      <= size_hi_in;
         payload_left_ff <= payload_left_in;
         prefix_pos_ff   <= prefix_pos_in;
      end
   end

   a2ab_emit #(
      .PAD_BYTES (PAD_BYTES)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept & gen),
      .load_desc  (desc),
      .load_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
